// ===== rtl/vqt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted quorum vote tally: shared package
// Sizes, item and result types, mode codes and the control types that pass
// between the sequencer and the tally registers.
// ----------------------------------------------------------------------------
package vqt_pkg;

  localparam int MAX_VALIDATORS = 64;
  localparam int WEIGHT_BITS    = 16;
  localparam int NUM_KINDS      = 4;
  localparam int ADDR_BITS      = $clog2(MAX_VALIDATORS);
  localparam int SUM_BITS       = WEIGHT_BITS + ADDR_BITS;
  localparam int CNT_BITS       = $clog2(MAX_VALIDATORS + 1);
  localparam int TOTAL_OUT_BITS = 22;
  localparam int ENTRY_BITS     = WEIGHT_BITS + NUM_KINDS;

  localparam logic [1:0] MODE_SET_WEIGHT = 2'd0;
  localparam logic [1:0] MODE_CAST_VOTE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR      = 2'd2;

  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [CNT_BITS-1:0]    count_t;
  typedef logic [NUM_KINDS-1:0]   marks_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [5:0]  validator_id;
    logic [15:0] weight;
    logic [1:0]  vote_kind;
  } item_t;

  typedef struct packed {
    logic        prevote_quorum;
    logic        precommit_quorum;
    logic        nil_prevote_quorum;
    logic        nil_precommit_quorum;
    logic [21:0] total_power_out;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TEST,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic       clear;
    logic       upd_weight;
    logic       upd_vote;
    logic       test;
    logic [1:0] kind;
    weight_t    old_weight;
    weight_t    new_weight;
    marks_t     marks;
  } tally_cmd_t;

  typedef struct packed {
    marks_t flags;
    sum_t   total;
  } tally_status_t;

endpackage

// ===== rtl/vqt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted quorum vote tally: validator entry RAM
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module vqt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/vqt_tally.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted quorum vote tally: tally registers
// Holds total power, per-kind weight sums, voter counts and the sticky
// quorum flags, and applies the updates and threshold tests it is given.
// ----------------------------------------------------------------------------
module vqt_tally (
  input  logic                   clk,
  input  logic                   rst,
  input  vqt_pkg::tally_cmd_t    cmd,
  output vqt_pkg::tally_status_t status
);

  import vqt_pkg::*;

  sum_t   total;
  sum_t   sums   [NUM_KINDS];
  count_t counts [NUM_KINDS];
  marks_t flags;

  logic [SUM_BITS+1:0] triple_sum;
  logic [SUM_BITS+1:0] double_total;
  logic                enough;

  always_comb begin
    triple_sum   = {2'b00, sums[cmd.kind]} + {1'b0, sums[cmd.kind], 1'b0};
    double_total = {1'b0, total, 1'b0};
    enough       = cmd.kind[1] || (counts[cmd.kind] >= count_t'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
      flags <= '0;
      for (int k = 0; k < NUM_KINDS; k++) begin
        sums[k]   <= '0;
        counts[k] <= '0;
      end
    end else begin
      if (cmd.clear) begin
        flags <= '0;
        for (int k = 0; k < NUM_KINDS; k++) begin
          sums[k]   <= '0;
          counts[k] <= '0;
        end
      end
      if (cmd.upd_weight) begin
        total <= total - sum_t'(cmd.old_weight) + sum_t'(cmd.new_weight);
        for (int k = 0; k < NUM_KINDS; k++) begin
          if (cmd.marks[k]) begin
            sums[k] <= sums[k] - sum_t'(cmd.old_weight) + sum_t'(cmd.new_weight);
          end
        end
      end
      if (cmd.upd_vote && !cmd.marks[cmd.kind]) begin
        sums[cmd.kind]   <= sums[cmd.kind] + sum_t'(cmd.old_weight);
        counts[cmd.kind] <= counts[cmd.kind] + count_t'(1);
      end
      if (cmd.test && enough && (triple_sum > double_total)) begin
        flags[cmd.kind] <= 1'b1;
      end
    end
  end

  assign status.flags = flags;
  assign status.total = total;

endmodule

// ===== rtl/weighted_quorum_vote_tally_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted quorum vote tally unit
// Each item sets a validator weight, casts a vote or clears the round, and
// returns the four quorum flags with the total power.
// ----------------------------------------------------------------------------
// Each item holds the unit until its result is loaded. The cycle in which it
// is accepted starts the read of the validator's entry from the RAM. The next
// cycle writes the entry back and updates the tallies, the one after runs the
// quorum test, and ST_DONE then loads the result register. A new item is not
// accepted until the result of the last one has been loaded. A finished
// result may wait in its register while the next item is taken; that item
// then waits in its last cycle, with the input stalled, until the earlier
// result has been taken.
// Validator entries are cleared by valid bits, so there is no clearing pass
// after reset.
module weighted_quorum_vote_tally_unit (
  input  logic             clk,
  input  logic             rst,
  input  vqt_pkg::item_t   item,
  input  logic             item_valid,
  output logic             item_stall,
  output vqt_pkg::result_t result,
  output logic             result_valid,
  input  logic             result_stall
);

  import vqt_pkg::*;

  state_t                  state;
  state_t                  state_next;
  item_t                   cur;
  logic [MAX_VALIDATORS-1:0] weight_valid;
  logic [MAX_VALIDATORS-1:0] marks_valid;

  logic                    accept;
  logic                    load;
  logic                    id_ok;
  logic [ADDR_BITS-1:0]    addr;
  logic                    we;
  logic [ENTRY_BITS-1:0]   wdata;
  logic [ENTRY_BITS-1:0]   rdata;
  weight_t                 old_weight;
  weight_t                 new_weight;
  marks_t                  old_marks;
  marks_t                  kind_bit;
  tally_cmd_t              cmd;
  tally_status_t           status;

  assign accept     = item_valid && !item_stall;
  assign addr       = ADDR_BITS'(cur.validator_id);
  assign id_ok      = 32'(cur.validator_id) < MAX_VALIDATORS;
  assign old_weight = weight_valid[addr] ? rdata[ENTRY_BITS-1:NUM_KINDS] : '0;
  assign old_marks  = marks_valid[addr] ? rdata[NUM_KINDS-1:0] : '0;
  assign new_weight = WEIGHT_BITS'(cur.weight);
  assign kind_bit   = marks_t'(1) << cur.vote_kind;

  vqt_ram #(
    .DEPTH (MAX_VALIDATORS),
    .WIDTH (ENTRY_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (wdata),
    .re    (accept),
    .raddr (ADDR_BITS'(item.validator_id)),
    .rdata (rdata)
  );

  vqt_tally u_tally (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    item_stall     = 1'b1;
    load           = 1'b0;
    we             = 1'b0;
    wdata          = {old_weight, old_marks};
    cmd            = '0;
    cmd.kind       = cur.vote_kind;
    cmd.old_weight = old_weight;
    cmd.new_weight = new_weight;
    cmd.marks      = old_marks;
    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cur.mode == MODE_CLEAR) begin
          cmd.clear = 1'b1;
        end else if (id_ok && cur.mode == MODE_SET_WEIGHT) begin
          cmd.upd_weight = 1'b1;
          we             = 1'b1;
          wdata          = {new_weight, old_marks};
        end else if (id_ok && cur.mode == MODE_CAST_VOTE) begin
          cmd.upd_vote = 1'b1;
          we           = 1'b1;
          wdata        = {old_weight, old_marks | kind_bit};
        end
        state_next = ST_TEST;
      end
      ST_TEST: begin
        cmd.test   = id_ok && (cur.mode == MODE_CAST_VOTE);
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_valid <= '0;
      marks_valid  <= '0;
    end else begin
      if (we) begin
        weight_valid[addr] <= 1'b1;
        marks_valid[addr]  <= 1'b1;
      end
      if (cmd.clear) begin
        marks_valid <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.prevote_quorum       <= status.flags[0];
      result.precommit_quorum     <= status.flags[1];
      result.nil_prevote_quorum   <= status.flags[2];
      result.nil_precommit_quorum <= status.flags[3];
      result.total_power_out      <= TOTAL_OUT_BITS'(status.total);
    end
  end

endmodule

// ===== rtl/vqt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted quorum vote tally: port checker
// Watches the item and result channels of the top level over time.
// ----------------------------------------------------------------------------
module vqt_checker (
  input logic             clk,
  input logic             rst,
  input vqt_pkg::item_t   item,
  input logic             item_valid,
  input logic             item_stall,
  input vqt_pkg::result_t result,
  input logic             result_valid,
  input logic             result_stall
);

  import vqt_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("Stalled result changed or was dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("Item taken while the previous one is still in progress.");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !result_valid |=> !result_valid)
    else $error("Result offered in the cycle after its item was taken.");

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.total_power_out <= 22'd4194240)
    else $error("Total power beyond the sum of all maximum weights.");

endmodule

bind weighted_quorum_vote_tally_unit vqt_checker u_vqt_checker (.*);
